### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rotation matrix pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvm assertion failed");

`endif

### src/rvm_pkg.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix package
// Constants, tables and stage types shared by the pipeline modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvm_pkg;

    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 31;
    localparam int RED_STEPS  = 4;
    localparam int COR_STEPS  = 32;
    localparam int ROT_STAGES = RED_STEPS + COR_STEPS;

    localparam logic [33:0]        HALF_PI_Q30 = 34'h0_6487_ED51;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic signed [36:0] ONE_Q30     = 37'sh0_4000_0000;
    localparam logic [30:0]        QUO_ONE     = 31'h4000_0000;

    localparam logic [31:0] ATAN_Q30 [COR_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Three Q3.28 components, x at index 0.
    typedef logic [2:0][31:0] t_vec;

    typedef struct packed {
        logic [63:0] n;
        logic [31:0] q;
        logic [33:0] rem;
        t_vec        vec;
    } t_sqrt_st;

    typedef struct packed {
        logic [31:0]       theta;
        logic [2:0]        neg;
        logic [2:0]        bring;
        logic [2:0][31:0]  rem;
        logic [2:0][30:0]  quo;
        logic [3:0]        quad;
        logic [33:0]       z;
        logic signed [33:0] x;
        logic signed [33:0] y;
    } t_rot_st;

    typedef struct packed {
        logic               zero;
        logic [1:0]         quad;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic [2:0][31:0]   u;
    } t_rot_res;

endpackage

### src/rvm_vec_if.sv
// ----------------------------------------------------------------------------
// Rotation vector channel
// Valid/ready channel carrying one rotation vector per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvm_vec_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;

    modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
    modport sink (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

### src/rvm_mat_if.sv
// ----------------------------------------------------------------------------
// Rotation matrix channel
// Valid/ready channel carrying one 3x3 matrix per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvm_mat_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;

    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    input ready);
    modport sink (input valid, input m00, input m01, input m02, input m10,
                  input m11, input m12, input m20, input m21, input m22,
                  output ready);
endinterface

### src/rvm_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit square root of a 64-bit sum, one result bit per stage,
// with the rotation vector carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvm_sqrt import rvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_sum,
    input  t_vec        i_vec,
    output logic        o_vld,
    output logic [31:0] o_theta,
    output t_vec        o_vec
);

    logic     r_vld [SQ_STEPS];
    t_sqrt_st r_st  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
        t_sqrt_st w_prev;
        t_sqrt_st n_st;
        logic     w_pv;

        if (k == 0) begin : g_head
            always_comb begin
                w_prev     = '0;
                w_prev.n   = i_sum;
                w_prev.vec = i_vec;
            end
            assign w_pv = i_vld;
        end else begin : g_link
            assign w_prev = r_st[k-1];
            assign w_pv   = r_vld[k-1];
        end

        always_comb begin
            logic [35:0] cur;
            logic [35:0] trial;
            cur   = {w_prev.rem, w_prev.n[63:62]};
            trial = {2'b00, w_prev.q, 2'b01};
            n_st     = w_prev;
            n_st.n   = {w_prev.n[61:0], 2'b00};
            if (cur >= trial) begin
                n_st.rem = 34'(cur - trial);
                n_st.q   = {w_prev.q[30:0], 1'b1};
            end else begin
                n_st.rem = cur[33:0];
                n_st.q   = {w_prev.q[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_vld   = r_vld[SQ_STEPS-1];
    assign o_theta = r_st[SQ_STEPS-1].q;
    assign o_vec   = r_st[SQ_STEPS-1].vec;

endmodule

### src/rvm_rotor.sv
// ----------------------------------------------------------------------------
// Angle and axis pipeline
// Quadrant reduction and CORDIC for cos/sin of theta, with three restoring
// dividers forming the unit axis in the same stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rvm_rotor import rvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_theta,
    input  t_vec        i_vec,
    output logic        o_vld,
    output t_rot_res    o_res
);

    logic    r_vld [ROT_STAGES];
    t_rot_st r_st  [ROT_STAGES];
    t_rot_st w_prep;
    t_rot_st w_last;

    always_comb begin
        logic [31:0] mag;
        w_prep       = '0;
        w_prep.theta = i_theta;
        w_prep.z     = {i_theta, 2'b00};
        w_prep.x     = CORDIC_GAIN;
        w_prep.y     = '0;
        for (int l = 0; l < 3; l++) begin
            mag             = i_vec[l][31] ? 32'(-i_vec[l]) : i_vec[l];
            w_prep.neg[l]   = i_vec[l][31];
            w_prep.rem[l]   = {1'b0, mag[31:1]};
            w_prep.bring[l] = mag[0];
        end
    end

    for (genvar k = 0; k < ROT_STAGES; k++) begin : g_st
        localparam int QB = (k < RED_STEPS) ? RED_STEPS - 1 - k : 0;
        localparam int CK = (k >= RED_STEPS) ? k - RED_STEPS : 0;
        t_rot_st w_prev;
        t_rot_st n_st;
        logic    w_pv;

        if (k == 0) begin : g_head
            assign w_prev = w_prep;
            assign w_pv   = i_vld;
        end else begin : g_link
            assign w_prev = r_st[k-1];
            assign w_pv   = r_vld[k-1];
        end

        always_comb begin
            logic [32:0]        cur;
            logic [33:0]        lim;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            n_st = w_prev;
            lim  = HALF_PI_Q30 << QB;
            xs   = w_prev.x >>> CK;
            ys   = w_prev.y >>> CK;
            if (k < DIV_STEPS) begin
                for (int l = 0; l < 3; l++) begin
                    cur = {w_prev.rem[l], (k == 0) ? w_prev.bring[l] : 1'b0};
                    if (cur >= {1'b0, w_prev.theta}) begin
                        n_st.rem[l] = 32'(cur - {1'b0, w_prev.theta});
                        n_st.quo[l] = {w_prev.quo[l][29:0], 1'b1};
                    end else begin
                        n_st.rem[l] = cur[31:0];
                        n_st.quo[l] = {w_prev.quo[l][29:0], 1'b0};
                    end
                end
            end
            if (k < RED_STEPS) begin
                if (w_prev.z >= lim) begin
                    n_st.z        = w_prev.z - lim;
                    n_st.quad[QB] = 1'b1;
                end
            end else begin
                if (!w_prev.z[33]) begin
                    n_st.x = w_prev.x - ys;
                    n_st.y = w_prev.y + xs;
                    n_st.z = w_prev.z - 34'(ATAN_Q30[CK]);
                end else begin
                    n_st.x = w_prev.x + ys;
                    n_st.y = w_prev.y - xs;
                    n_st.z = w_prev.z + 34'(ATAN_Q30[CK]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign w_last = r_st[ROT_STAGES-1];
    assign o_vld  = r_vld[ROT_STAGES-1];

    always_comb begin
        o_res.zero = (w_last.theta == '0);
        o_res.quad = w_last.quad[1:0];
        o_res.x    = w_last.x;
        o_res.y    = w_last.y;
        for (int l = 0; l < 3; l++) begin
            o_res.u[l] = w_last.neg[l] ? 32'(-{1'b0, w_last.quo[l]}) : {1'b0, w_last.quo[l]};
        end
    end

    // After reduction the residual angle lies below a quarter turn.
    `RVM_ASSERT_IMP(a_reduced_angle, i_clk, i_rst_n, r_vld[RED_STEPS-1], r_st[RED_STEPS-1].z < HALF_PI_Q30)
    // Each axis component magnitude is at most one.
    `RVM_ASSERT_IMP(a_unit_bound, i_clk, i_rst_n, o_vld && !o_res.zero, (w_last.quo[0] <= QUO_ONE) && (w_last.quo[1] <= QUO_ONE) && (w_last.quo[2] <= QUO_ONE))

endmodule

### src/rotation_vector_to_matrix_unit.sv
// ----------------------------------------------------------------------------
// Rotation vector to rotation matrix
// Converts an axis-angle rotation vector into a 3x3 rotation matrix by the
// Rodrigues formula, using a square root, CORDIC and dividers in a pipeline.
// ----------------------------------------------------------------------------
// The unit accepts one rotation vector per clock while the output is not
// held, and returns its matrix through register stages for squaring and
// summing, the bit-per-stage square root, quadrant reduction and CORDIC (the
// axis dividers run in the same stages), and products, sums and saturation
// into the output register. When the output is held by the sink, the whole
// pipeline holds, and input ready falls in that same cycle. A zero-length
// vector gives the identity matrix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotation_vector_to_matrix_unit import rvm_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rvm_vec_if.sink    i_rot,
    rvm_mat_if.source  o_mat
);

    localparam int IN_UP  = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
    localparam int IN_DN  = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
    localparam int IN_W   = DATA_WIDTH + IN_UP;
    localparam int OUT_UP = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
    localparam int OUT_DN = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
    localparam int EW     = 37 + OUT_UP;

    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO =
        {{(EW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam int PD_XX = 0;
    localparam int PD_YY = 1;
    localparam int PD_ZZ = 2;
    localparam int PD_XY = 3;
    localparam int PD_XZ = 4;
    localparam int PD_YZ = 5;
    localparam int US_X  = 0;
    localparam int US_Y  = 1;
    localparam int US_Z  = 2;
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic w_en;

    // Input conversion and squares.
    logic signed [31:0] w_r   [3];
    logic signed [63:0] w_sq  [3];
    logic               r_s0_vld;
    t_vec               r_s0_vec;
    logic [62:0]        r_s0_sq [3];
    logic               r_s1_vld;
    t_vec               r_s1_vec;
    logic [63:0]        r_s1_sum;

    logic        w_sq_vld;
    logic [31:0] w_theta;
    t_vec        w_sq_vec;
    logic        w_rot_vld;
    t_rot_res    w_rot;

    logic signed [33:0] w_c;
    logic signed [33:0] w_s;
    logic               r_p0_vld;
    logic               r_p0_zero;
    logic signed [33:0] r_p0_c;
    logic signed [33:0] r_p0_s;
    logic signed [34:0] r_p0_d;
    logic signed [31:0] r_p0_u [3];

    logic signed [63:0] w_pp [6];
    logic signed [65:0] w_us [3];
    logic               r_p1_vld;
    logic               r_p1_zero;
    logic signed [33:0] r_p1_c;
    logic signed [34:0] r_p1_d;
    logic signed [33:0] r_p1_pp [6];
    logic signed [35:0] r_p1_us [3];

    logic signed [68:0] w_pd [6];
    logic               r_p2_vld;
    logic               r_p2_zero;
    logic signed [33:0] r_p2_c;
    logic signed [35:0] r_p2_pd [6];
    logic signed [35:0] r_p2_us [3];

    logic signed [36:0]           w_m [9];
    logic signed [EW-1:0]         w_v [9];
    logic signed [DATA_WIDTH-1:0] w_o [9];
    logic                         r_out_vld;
    logic signed [DATA_WIDTH-1:0] r_out_m [9];

    assign w_en        = !r_out_vld || o_mat.ready;
    assign i_rot.ready = w_en;

    assign w_r[0] = 32'((IN_W'(i_rot.rot_x) <<< IN_UP) >>> IN_DN);
    assign w_r[1] = 32'((IN_W'(i_rot.rot_y) <<< IN_UP) >>> IN_DN);
    assign w_r[2] = 32'((IN_W'(i_rot.rot_z) <<< IN_UP) >>> IN_DN);

    for (genvar l = 0; l < 3; l++) begin : g_sq
        assign w_sq[l] = w_r[l] * w_r[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_p0_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld  <= i_rot.valid;
            r_s1_vld  <= r_s0_vld;
            r_p0_vld  <= w_rot_vld;
            r_p1_vld  <= r_p0_vld;
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s0_vec[l] <= w_r[l];
                r_s0_sq[l]  <= w_sq[l][62:0];
            end
            r_s1_vec <= r_s0_vec;
            r_s1_sum <= 64'(r_s0_sq[0]) + 64'(r_s0_sq[1]) + 64'(r_s0_sq[2]);
        end
    end

    rvm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s1_vld),
        .i_sum   (r_s1_sum),
        .i_vec   (r_s1_vec),
        .o_vld   (w_sq_vld),
        .o_theta (w_theta),
        .o_vec   (w_sq_vec)
    );

    rvm_rotor u_rotor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_theta (w_theta),
        .i_vec   (w_sq_vec),
        .o_vld   (w_rot_vld),
        .o_res   (w_rot)
    );

    // Quadrant unfolding of the CORDIC result.
    always_comb begin
        case (w_rot.quad)
            QUAD_0: begin
                w_c = w_rot.x;
                w_s = w_rot.y;
            end
            QUAD_1: begin
                w_c = -w_rot.y;
                w_s = w_rot.x;
            end
            QUAD_2: begin
                w_c = -w_rot.x;
                w_s = -w_rot.y;
            end
            default: begin
                w_c = w_rot.y;
                w_s = -w_rot.x;
            end
        endcase
    end

    for (genvar j = 0; j < 6; j++) begin : g_pp
        assign w_pp[j] = r_p0_u[PA[j]] * r_p0_u[PB[j]];
        assign w_pd[j] = r_p1_pp[j] * r_p1_d;
    end

    for (genvar l = 0; l < 3; l++) begin : g_us
        assign w_us[l] = r_p0_u[l] * r_p0_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_zero <= w_rot.zero;
            r_p0_c    <= w_c;
            r_p0_s    <= w_s;
            r_p0_d    <= 35'(ONE_Q30) - 35'(w_c);
            for (int l = 0; l < 3; l++) begin
                r_p0_u[l] <= $signed(w_rot.u[l]);
            end

            r_p1_zero <= r_p0_zero;
            r_p1_c    <= r_p0_c;
            r_p1_d    <= r_p0_d;
            for (int j = 0; j < 6; j++) begin
                r_p1_pp[j] <= 34'(w_pp[j] >>> 30);
            end
            for (int l = 0; l < 3; l++) begin
                r_p1_us[l] <= 36'(w_us[l] >>> 30);
            end

            r_p2_zero <= r_p1_zero;
            r_p2_c    <= r_p1_c;
            for (int j = 0; j < 6; j++) begin
                r_p2_pd[j] <= 36'(w_pd[j] >>> 30);
            end
            for (int l = 0; l < 3; l++) begin
                r_p2_us[l] <= r_p1_us[l];
            end

            for (int i = 0; i < 9; i++) begin
                r_out_m[i] <= w_o[i];
            end
        end
    end

    // Matrix assembly, identity for a zero vector, then output scaling and saturation.
    always_comb begin
        if (r_p2_zero) begin
            for (int i = 0; i < 9; i++) begin
                w_m[i] = (i % 4 == 0) ? ONE_Q30 : '0;
            end
        end else begin
            w_m[0] = 37'(r_p2_c) + 37'(r_p2_pd[PD_XX]);
            w_m[1] = 37'(r_p2_pd[PD_XY]) - 37'(r_p2_us[US_Z]);
            w_m[2] = 37'(r_p2_pd[PD_XZ]) + 37'(r_p2_us[US_Y]);
            w_m[3] = 37'(r_p2_pd[PD_XY]) + 37'(r_p2_us[US_Z]);
            w_m[4] = 37'(r_p2_c) + 37'(r_p2_pd[PD_YY]);
            w_m[5] = 37'(r_p2_pd[PD_YZ]) - 37'(r_p2_us[US_X]);
            w_m[6] = 37'(r_p2_pd[PD_XZ]) - 37'(r_p2_us[US_Y]);
            w_m[7] = 37'(r_p2_pd[PD_YZ]) + 37'(r_p2_us[US_X]);
            w_m[8] = 37'(r_p2_c) + 37'(r_p2_pd[PD_ZZ]);
        end
        for (int i = 0; i < 9; i++) begin
            w_v[i] = (EW'(w_m[i]) <<< OUT_UP) >>> OUT_DN;
            if (w_v[i] > SAT_HI) begin
                w_o[i] = SAT_HI[DATA_WIDTH-1:0];
            end else if (w_v[i] < SAT_LO) begin
                w_o[i] = SAT_LO[DATA_WIDTH-1:0];
            end else begin
                w_o[i] = w_v[i][DATA_WIDTH-1:0];
            end
        end
    end

    assign o_mat.valid = r_out_vld;
    assign o_mat.m00   = r_out_m[0];
    assign o_mat.m01   = r_out_m[1];
    assign o_mat.m02   = r_out_m[2];
    assign o_mat.m10   = r_out_m[3];
    assign o_mat.m11   = r_out_m[4];
    assign o_mat.m12   = r_out_m[5];
    assign o_mat.m20   = r_out_m[6];
    assign o_mat.m21   = r_out_m[7];
    assign o_mat.m22   = r_out_m[8];

    // A zero vector leaves the pipeline as the identity matrix.
    `RVM_ASSERT_NXT(a_zero_identity, i_clk, i_rst_n, w_en && r_p2_vld && r_p2_zero, (o_mat.m01 == '0) && (o_mat.m10 == '0) && (o_mat.m00 == o_mat.m11) && (o_mat.m22 == o_mat.m00))
    // A held output freezes the internal stages.
    `RVM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_p2_vld) && $stable(r_p0_vld) && $stable(r_s0_vld))

endmodule
